FILE: rtl/core/tsalu_pkg.sv
// Shared types and constants for the seconds/nanoseconds time ALU.
// Used by every module in rtl/core; depends on nothing else.
package tsalu_pkg;

  localparam int FUNC_W   = 2;
  localparam int SEC_W    = 32;
  localparam int NSEC_W   = 30;
  localparam int FACTOR_W = 10;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes of the func field.
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCALE = 2'd2;

  // One second in nanoseconds, one bit wider than the nanosecond field.
  localparam logic [NSEC_W:0]   NS_PER_SEC = 31'd1000000000;
  localparam logic [NSEC_W-1:0] NS_MAX     = 30'd999999999;

  // Work class chosen by the front end.
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ADD,
    CLS_SUB,
    CLS_SCALE
  } tsalu_cls_e;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SEC_W-1:0]    a_sec;
    logic [NSEC_W-1:0]   a_nsec;
    logic [SEC_W-1:0]    b_sec;
    logic [NSEC_W-1:0]   b_nsec;
    logic [FACTOR_W-1:0] factor;
  } tsalu_cmd_t;

  typedef struct packed {
    logic [SEC_W-1:0]  r_sec;
    logic [NSEC_W-1:0] r_nsec;
  } tsalu_res_t;

  // Classified job as held in the queue.
  typedef struct packed {
    tsalu_cls_e          cls;
    logic [SEC_W-1:0]    a_sec;
    logic [NSEC_W-1:0]   a_nsec;
    logic [SEC_W-1:0]    b_sec;
    logic [NSEC_W-1:0]   b_nsec;
    logic [FACTOR_W-1:0] factor;
  } tsalu_job_t;

  // Queue status seen by the top level and the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } tsalu_qstat_t;

endpackage

FILE: rtl/core/tsalu_front.sv
// Front end: saturates nanoseconds, masks seconds and factor, and classifies
// each command into a job for the back end. Depends on tsalu_pkg.
module tsalu_front #(
  parameter int SEC_BITS    = 32,
  parameter int FACTOR_BITS = 10
) (
  input  tsalu_pkg::tsalu_cmd_t cmd_i,
  output tsalu_pkg::tsalu_job_t job_o
);
  import tsalu_pkg::*;

  localparam int SW = (SEC_BITS < SEC_W) ? SEC_BITS : SEC_W;
  localparam int FW = (FACTOR_BITS < FACTOR_W) ? FACTOR_BITS : FACTOR_W;
  localparam logic [SEC_W-1:0]    SecMask    = SEC_W'((64'd1 << SW) - 64'd1);
  localparam logic [FACTOR_W-1:0] FactorMask = FACTOR_W'((32'd1 << FW) - 32'd1);

  logic [SEC_W-1:0]    a_sec, b_sec;
  logic [NSEC_W-1:0]   a_nsec, b_nsec;
  logic [FACTOR_W-1:0] factor;
  logic                not_greater;

  assign a_sec  = cmd_i.a_sec & SecMask;
  assign b_sec  = cmd_i.b_sec & SecMask;
  assign a_nsec = (cmd_i.a_nsec > NS_MAX) ? NS_MAX : cmd_i.a_nsec;
  assign b_nsec = (cmd_i.b_nsec > NS_MAX) ? NS_MAX : cmd_i.b_nsec;
  assign factor = cmd_i.factor & FactorMask;

  assign not_greater = (a_sec < b_sec) || ((a_sec == b_sec) && (a_nsec <= b_nsec));

  always_comb begin
    job_o.a_sec  = a_sec;
    job_o.a_nsec = a_nsec;
    job_o.b_sec  = b_sec;
    job_o.b_nsec = b_nsec;
    job_o.factor = factor;
    case (cmd_i.func)
      FUNC_ADD:   job_o.cls = CLS_ADD;
      // floor at zero when the first time does not exceed the second
      FUNC_SUB:   job_o.cls = not_greater ? CLS_ZERO : CLS_SUB;
      FUNC_SCALE: job_o.cls = (factor == '0) ? CLS_ZERO : CLS_SCALE;
      default:    job_o.cls = CLS_ZERO;
    endcase
  end

endmodule

FILE: rtl/core/tsalu_queue.sv
// Short job queue between front and back end.
// Depends on tsalu_pkg for the job type and depth.
module tsalu_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  tsalu_pkg::tsalu_job_t   push_job_i,
  input  logic                    pop_i,
  output tsalu_pkg::tsalu_job_t   head_o,
  output tsalu_pkg::tsalu_qstat_t stat_o
);
  import tsalu_pkg::*;

  tsalu_job_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: rtl/core/tsalu_back.sv
// Back end: executes one job at a time. Add and subtract are combinational on
// the popped job; scale runs one carry-corrected addition per cycle. Depends on tsalu_pkg.
module tsalu_back #(
  parameter int SEC_BITS    = 32,
  parameter int FACTOR_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tsalu_pkg::tsalu_qstat_t qstat_i,
  input  tsalu_pkg::tsalu_job_t   job_i,
  output logic                    pop_o,
  output logic                    done_o,
  output tsalu_pkg::tsalu_res_t   result_o
);
  import tsalu_pkg::*;

  localparam int SW = (SEC_BITS < SEC_W) ? SEC_BITS : SEC_W;
  localparam int FW = (FACTOR_BITS < FACTOR_W) ? FACTOR_BITS : FACTOR_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SCALE = 1'b1;

  logic              state_q, state_d;
  logic [SW-1:0]     step_sec_q, acc_sec_q, acc_sec_d;
  logic [NSEC_W-1:0] step_ns_q, acc_ns_q, acc_ns_d;
  logic [FW-1:0]     cnt_q;
  logic              done_q, done_d;
  tsalu_res_t        res_q, res_d;

  // combinational add and subtract
  logic [NSEC_W:0] add_ns, sub_ns, acc_ns_sum;
  logic            add_carry, sub_borrow, acc_carry;
  logic [SW-1:0]   add_sec, sub_sec;

  assign add_ns    = {1'b0, job_i.a_nsec} + {1'b0, job_i.b_nsec};
  assign add_carry = (add_ns >= NS_PER_SEC);
  assign add_sec   = job_i.a_sec[SW-1:0] + job_i.b_sec[SW-1:0] + SW'(add_carry);

  assign sub_borrow = (job_i.a_nsec < job_i.b_nsec);
  assign sub_ns     = {1'b0, job_i.a_nsec} + (sub_borrow ? NS_PER_SEC : '0)
                      - {1'b0, job_i.b_nsec};
  assign sub_sec    = job_i.a_sec[SW-1:0] - job_i.b_sec[SW-1:0] - SW'(sub_borrow);

  // one scale pass
  assign acc_ns_sum = {1'b0, acc_ns_q} + {1'b0, step_ns_q};
  assign acc_carry  = (acc_ns_sum >= NS_PER_SEC);
  assign acc_ns_d   = acc_carry ? NSEC_W'(acc_ns_sum - NS_PER_SEC) : NSEC_W'(acc_ns_sum);
  assign acc_sec_d  = acc_sec_q + step_sec_q + SW'(acc_carry);

  assign pop_o = (state_q == ST_IDLE) && !qstat_i.empty;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (job_i.cls)
            CLS_ADD: begin
              done_d       = 1'b1;
              res_d.r_sec  = SEC_W'(add_sec);
              res_d.r_nsec = add_carry ? NSEC_W'(add_ns - NS_PER_SEC) : NSEC_W'(add_ns);
            end
            CLS_SUB: begin
              done_d       = 1'b1;
              res_d.r_sec  = SEC_W'(sub_sec);
              res_d.r_nsec = NSEC_W'(sub_ns);
            end
            CLS_SCALE: begin
              state_d = ST_SCALE;
            end
            default: begin
              done_d       = 1'b1;
              res_d.r_sec  = '0;
              res_d.r_nsec = '0;
            end
          endcase
        end
      end
      ST_SCALE: begin
        // last pass: deliver the accumulated time
        if (cnt_q == FW'(1)) begin
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          res_d.r_sec  = SEC_W'(acc_sec_d);
          res_d.r_nsec = acc_ns_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == ST_IDLE) begin
      step_sec_q <= job_i.a_sec[SW-1:0];
      step_ns_q  <= job_i.a_nsec;
      acc_sec_q  <= '0;
      acc_ns_q   <= '0;
      cnt_q      <= job_i.factor[FW-1:0];
    end else begin
      acc_sec_q <= acc_sec_d;
      acc_ns_q  <= acc_ns_d;
      cnt_q     <= cnt_q - FW'(1);
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/core/seconds_nanoseconds_time_alu.sv
// Top level of the seconds/nanoseconds time ALU: front end, job queue, back end.
// Depends on tsalu_pkg, tsalu_front, tsalu_queue and tsalu_back.
//
// A command is taken when start is high and busy is low; busy rises only
// while the two-entry job queue is full. Each command yields one result,
// shown on result_o for one cycle with done_o high; there is no way to hold
// it off, so the receiver must take it in that cycle. Results leave in
// command order. The back end handles add, subtract and any zero result
// as soon as it pops the job, and scale as one accumulate per cycle with
// carry correction until the factor is spent, so long scale jobs set the
// sustained rate; the queue keeps taking commands meanwhile until full.
// An accepted command is registered in the queue, popped by an idle back
// end, and its result is registered onto result_o with done_o.
module seconds_nanoseconds_time_alu #(
  parameter int SEC_BITS    = 32,
  parameter int FACTOR_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  tsalu_pkg::tsalu_cmd_t cmd_i,
  output logic                  busy,
  output logic                  done_o,
  output tsalu_pkg::tsalu_res_t result_o
);
  import tsalu_pkg::*;

  tsalu_job_t   front_job, head_job;
  tsalu_qstat_t qstat;
  logic         push, pop;

  assign busy = qstat.full;
  assign push = start && !busy;

  tsalu_front #(
    .SEC_BITS    (SEC_BITS),
    .FACTOR_BITS (FACTOR_BITS)
  ) u_front (
    .cmd_i (cmd_i),
    .job_o (front_job)
  );

  tsalu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (front_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (qstat)
  );

  tsalu_back #(
    .SEC_BITS    (SEC_BITS),
    .FACTOR_BITS (FACTOR_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .job_i    (head_job),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for seconds_nanoseconds_time_alu: add, floored subtract and scale.
// Depends on tsalu_pkg for the command and result structs and the operation codes.
// Directed edge cases come first, then random commands, with random sender idling in all but the last batch.
module tb_top;
  import tsalu_pkg::*;

  // The selector value that names no operation.
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int HOLD_LIMIT  = 8000;
  localparam int TAIL_CYCLES = 20;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  tsalu_cmd_t cmd_i  = '0;
  logic       busy;
  logic       done_o;
  tsalu_res_t result_o;

  tsalu_res_t expected_times[$];
  int         err_cnt     = 0;
  int         checked_cnt = 0;
  int         quiet_cnt   = 0;
  int         op_cnt[4]   = '{0, 0, 0, 0};
  bit         idle_on     = 1'b1;

  seconds_nanoseconds_time_alu dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] ns_sat(input logic [NSEC_W-1:0] ns);
    return (ns > NS_MAX) ? 64'(NS_MAX) : 64'(ns);
  endfunction

  function automatic tsalu_res_t predict_time_result(input tsalu_cmd_t c);
    logic [63:0] as_w, an_w, bs_w, bn_w, k_w, rs, rn, tot, one_sec;
    tsalu_res_t  r;
    one_sec = 64'(NS_PER_SEC);
    as_w = 64'(c.a_sec);
    bs_w = 64'(c.b_sec);
    an_w = ns_sat(c.a_nsec);
    bn_w = ns_sat(c.b_nsec);
    k_w  = 64'(c.factor);
    rs   = '0;
    rn   = '0;
    case (c.func)
      FUNC_ADD: begin
        rs = as_w + bs_w;
        rn = an_w + bn_w;
        if (rn >= one_sec) begin
          rs = rs + 64'd1;
          rn = rn - one_sec;
        end
      end
      FUNC_SUB: begin
        // floor at zero unless the first time is strictly later
        if (as_w > bs_w || (as_w == bs_w && an_w > bn_w)) begin
          rs = as_w - bs_w;
          if (an_w < bn_w) begin
            rn = an_w + one_sec - bn_w;
            rs = rs - 64'd1;
          end else begin
            rn = an_w - bn_w;
          end
        end
      end
      FUNC_SCALE: begin
        tot = k_w * an_w;
        rs  = k_w * as_w + tot / one_sec;
        rn  = tot % one_sec;
      end
      default: begin
        rs = '0;
        rn = '0;
      end
    endcase
    r.r_sec  = rs[SEC_W-1:0];
    r.r_nsec = rn[NSEC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Compare results, record transfers and watch for a stuck block.
  always @(posedge clk_i) begin : check_results
    tsalu_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_times.size() == 0) begin
          report_mismatch($sformatf("result %0d s %0d ns with nothing pending",
                                    result_o.r_sec, result_o.r_nsec));
        end else begin
          want = expected_times.pop_front();
          if (result_o.r_sec !== want.r_sec)
            report_mismatch($sformatf("r_sec %0d, want %0d", result_o.r_sec, want.r_sec));
          if (result_o.r_nsec !== want.r_nsec)
            report_mismatch($sformatf("r_nsec %0d, want %0d", result_o.r_nsec, want.r_nsec));
          checked_cnt++;
        end
      end
      if (start && !busy) begin
        expected_times.push_back(predict_time_result(cmd_i));
        op_cnt[cmd_i.func]++;
      end
      if (done_o || (start && !busy)) quiet_cnt = 0;
      else quiet_cnt++;
      if (quiet_cnt >= HOLD_LIMIT) begin
        $display("tb: no transfer for %0d cycles", HOLD_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic tsalu_cmd_t make_cmd(input logic [FUNC_W-1:0] f,
                                          input logic [SEC_W-1:0] as,
                                          input logic [NSEC_W-1:0] an,
                                          input logic [SEC_W-1:0] bs,
                                          input logic [NSEC_W-1:0] bn,
                                          input logic [FACTOR_W-1:0] k);
    tsalu_cmd_t c;
    c.func   = f;
    c.a_sec  = as;
    c.a_nsec = an;
    c.b_sec  = bs;
    c.b_nsec = bn;
    c.factor = k;
    return c;
  endfunction

  function automatic logic [SEC_W-1:0] pick_sec();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SEC_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [NSEC_W-1:0] pick_nsec();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return NS_MAX;
      2:       return NSEC_W'($urandom_range(1000000000, 32'h3FFF_FFFF));
      3:       return NSEC_W'($urandom_range(999999000, 999999999));
      default: return NSEC_W'($urandom_range(0, 999999999));
    endcase
  endfunction

  function automatic tsalu_cmd_t random_cmd();
    tsalu_cmd_t c;
    int         sel;
    sel      = $urandom_range(0, 19);
    c.func   = (sel == 0) ? FUNC_NONE : (sel < 7) ? FUNC_ADD : (sel < 14) ? FUNC_SUB : FUNC_SCALE;
    c.a_sec  = pick_sec();
    c.a_nsec = pick_nsec();
    c.b_sec  = pick_sec();
    c.b_nsec = pick_nsec();
    // keep the two times close often, so subtract lands on both sides of zero
    if ($urandom_range(0, 1) == 0) begin
      c.b_sec = c.a_sec + SEC_W'($urandom_range(0, 2)) - SEC_W'(1);
      if ($urandom_range(0, 3) == 0) c.b_nsec = c.a_nsec;
    end
    // mostly short scale runs; a few long ones
    case ($urandom_range(0, 19))
      0:       c.factor = FACTOR_W'($urandom_range(0, 1023));
      1, 2:    c.factor = FACTOR_W'($urandom_range(16, 255));
      default: c.factor = FACTOR_W'($urandom_range(0, 15));
    endcase
    return c;
  endfunction

  // Entered just after a rising edge; returns at the edge of the transfer, or after a random idle gap.
  task automatic issue(input tsalu_cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      cmd_i <= random_cmd();
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Hold the sender off until every pending result has come out.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_times.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_add();
    issue(make_cmd(FUNC_ADD, '0, '0, '0, '0, '0));
    issue(make_cmd(FUNC_ADD, '1, NS_MAX, '1, NS_MAX, '1));
    issue(make_cmd(FUNC_ADD, 32'd7, 30'd500000000, 32'd9, 30'd500000000, '0));
    issue(make_cmd(FUNC_ADD, 32'd1, 30'd499999999, 32'd2, 30'd500000000, 10'd5));
    issue(make_cmd(FUNC_ADD, 32'hFFFF_FFFF, 30'd1, 32'd0, NS_MAX, '0));
  endtask

  task automatic test_sub();
    issue(make_cmd(FUNC_SUB, 32'd100, 30'd250, 32'd100, 30'd250, '0));
    issue(make_cmd(FUNC_SUB, 32'd100, 30'd250, 32'd100, 30'd251, '0));
    issue(make_cmd(FUNC_SUB, 32'd99, NS_MAX, 32'd100, 30'd0, '0));
    issue(make_cmd(FUNC_SUB, 32'd100, 30'd251, 32'd100, 30'd250, '1));
    issue(make_cmd(FUNC_SUB, 32'd101, 30'd0, 32'd100, NS_MAX, '0));
    issue(make_cmd(FUNC_SUB, '1, NS_MAX, '0, '0, '0));
    issue(make_cmd(FUNC_SUB, '0, 30'd1, '0, '0, '0));
  endtask

  task automatic test_scale();
    issue(make_cmd(FUNC_SCALE, $urandom(), 30'd123456789, '1, NS_MAX, 10'd0));
    issue(make_cmd(FUNC_SCALE, 32'd42, 30'd987654321, $urandom(), 30'd7, 10'd1));
    issue(make_cmd(FUNC_SCALE, 32'd3, 30'd600000000, '0, '0, 10'd2));
    issue(make_cmd(FUNC_SCALE, '1, NS_MAX, '1, NS_MAX, '1));
    issue(make_cmd(FUNC_SCALE, 32'd5, '1, '0, '0, 10'd3));
  endtask

  // Unused selector and nanoseconds above the legal range.
  task automatic test_odd_inputs();
    issue(make_cmd(FUNC_NONE, '1, NS_MAX, '1, NS_MAX, '1));
    issue(make_cmd(FUNC_NONE, $urandom(), 30'd12345, $urandom(), 30'd54321, 10'd9));
    issue(make_cmd(FUNC_ADD, 32'd1, '1, 32'd2, 30'd1000000000, '0));
    issue(make_cmd(FUNC_SUB, 32'd8, 30'd1000000005, 32'd8, NS_MAX, '0));
    issue(make_cmd(FUNC_SUB, 32'd8, '1, 32'd8, 30'd999999998, '0));
  endtask

  task automatic test_random(input int n, input bit allow_idle);
    for (int i = 0; i < n; i++) begin
      if (!allow_idle) idle_on = 1'b0;
      else if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      issue(random_cmd());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_add();
    test_sub();
    test_scale();
    test_odd_inputs();
    test_random(240, 1'b1);
    wait_drained();
    test_random(240, 1'b1);
    test_random(80, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_times.size() != 0)
      report_mismatch($sformatf("%0d results never came", expected_times.size()));

    $display("tb: %0d results checked: %0d add, %0d subtract, %0d scale, %0d unused selector",
             checked_cnt, op_cnt[FUNC_ADD], op_cnt[FUNC_SUB], op_cnt[FUNC_SCALE],
             op_cnt[FUNC_NONE]);
    $display("tb: %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
